>>> sv/bmpc_pkg.sv
// types, constants and status codes shared by the battery monitor poll classifier
// depends on nothing; imported by bmpc_update and battery_monitor_poll_classifier
`timescale 1ns / 1ps

package bmpc_pkg;

  localparam int unsigned UvW   = 23;
  localparam int unsigned PctW  = 7;
  localparam int unsigned ErrW  = 8;
  localparam int unsigned RawW  = 16;

  localparam int unsigned InDataW  = 40;
  localparam int unsigned OutDataW = 48;

  localparam logic [UvW-1:0]  UvPerLsb = 23'd1250;
  localparam logic [PctW-1:0] CapMax   = 7'd100;

  localparam logic [UvW-1:0]  CriticalUvRst = 23'd3200000;
  localparam logic [UvW-1:0]  LowUvRst      = 23'd3400000;
  localparam logic [PctW-1:0] FullPctRst    = 7'd95;
  localparam logic [ErrW-1:0] ErrLimitRst   = 8'd5;

  typedef enum logic [1:0] {
    RegCriticalUv = 2'd0,
    RegLowUv      = 2'd1,
    RegFullPct    = 2'd2,
    RegErrLimit   = 2'd3
  } cfg_reg_e;

  typedef enum logic [2:0] {
    BatUnknown     = 3'd0,
    BatDischarging = 3'd1,
    BatNotCharging = 3'd2,
    BatFull        = 3'd3,
    BatCharging    = 3'd4
  } bat_status_e;

  typedef enum logic [2:0] {
    LvlUnknown  = 3'd0,
    LvlCritical = 3'd1,
    LvlLow      = 3'd2,
    LvlFull     = 3'd3,
    LvlNormal   = 3'd4
  } cap_level_e;

  typedef enum logic [1:0] {
    ChgDischarging = 2'd0,
    ChgNotCharging = 2'd1,
    ChgCharging    = 2'd2
  } chg_status_e;

  typedef struct packed {
    logic [UvW-1:0]  critical_uv;
    logic [UvW-1:0]  low_uv;
    logic [PctW-1:0] full_pct;
    logic [ErrW-1:0] err_limit;
  } cfg_t;

  typedef struct packed {
    logic [UvW-1:0]  voltage;
    logic [PctW-1:0] capacity;
    logic            mains;
    logic            inhibit;
    logic            present;
    logic [ErrW-1:0] err_cnt;
  } state_t;

  typedef struct packed {
    logic            inhibit_pin;
    logic            mains_pin_ok;
    logic            mains_pin;
    logic [RawW-1:0] charge_raw;
    logic            charge_read_ok;
    logic [RawW-1:0] voltage_raw;
    logic            voltage_read_ok;
  } item_t;

  typedef struct packed {
    chg_status_e     charger_status;
    cap_level_e      charge_band;
    bat_status_e     battery_status;
    logic            charger_changed;
    logic            mains_changed;
    logic            battery_changed;
    logic            charging_inhibited;
    logic            mains_online;
    logic [PctW-1:0] capacity_percent;
    logic [UvW-1:0]  cell_microvolts;
    logic            battery_present;
  } result_t;

endpackage

>>> sv/bmpc_update.sv
// next-state and result logic for one poll sample
// depends on bmpc_pkg
`timescale 1ns / 1ps

module bmpc_update
  import bmpc_pkg::*;
(
  input  cfg_t    cfg_i,
  input  state_t  state_i,
  input  item_t   item_i,
  output state_t  state_o,
  output result_t result_o
);

  logic [UvW-1:0]  new_uv;
  logic [7:0]      pct_raw;
  logic [PctW-1:0] new_pct;
  logic            new_mains;
  logic [ErrW-1:0] err_inc;
  logic            bat_ch;
  logic            mains_ch;
  logic            chg_ch;
  state_t          nxt;

  assign new_uv    = UvW'(item_i.voltage_raw[RawW-1:4]) * UvPerLsb;
  assign pct_raw   = item_i.charge_raw[RawW-1:8];
  assign new_pct   = (pct_raw > 8'(CapMax)) ? CapMax : pct_raw[PctW-1:0];
  assign new_mains = item_i.mains_pin & item_i.mains_pin_ok;
  assign err_inc   = (state_i.err_cnt < cfg_i.err_limit) ? state_i.err_cnt + 8'd1
                                                          : state_i.err_cnt;

  always_comb begin
    nxt      = state_i;
    bat_ch   = 1'b0;
    mains_ch = 1'b0;
    chg_ch   = 1'b0;
    if (!item_i.voltage_read_ok) begin
      // failed voltage read: count it, drop presence at the limit
      nxt.err_cnt = err_inc;
      if (err_inc >= cfg_i.err_limit && state_i.present) begin
        bat_ch      = 1'b1;
        nxt.present = 1'b0;
      end
    end else if (!item_i.charge_read_ok) begin
      // voltage only
      nxt.err_cnt = '0;
      nxt.present = 1'b1;
      nxt.voltage = new_uv;
      bat_ch      = (state_i.voltage != new_uv);
    end else begin
      nxt.err_cnt  = '0;
      bat_ch       = !state_i.present || (state_i.voltage != new_uv) ||
                     (state_i.capacity != new_pct);
      mains_ch     = (state_i.mains != new_mains);
      chg_ch       = (state_i.inhibit != item_i.inhibit_pin);
      nxt.present  = 1'b1;
      nxt.voltage  = new_uv;
      nxt.capacity = new_pct;
      nxt.mains    = new_mains;
      nxt.inhibit  = item_i.inhibit_pin;
    end
  end

  logic full_cap;
  logic on_batt_nz;

  assign full_cap   = (nxt.capacity >= cfg_i.full_pct);
  assign on_batt_nz = !nxt.mains && (nxt.voltage != '0);

  always_comb begin
    result_o.battery_present    = nxt.present;
    result_o.cell_microvolts    = nxt.voltage;
    result_o.capacity_percent   = nxt.capacity;
    result_o.mains_online       = nxt.mains;
    result_o.charging_inhibited = nxt.inhibit;
    result_o.battery_changed    = bat_ch | mains_ch;
    result_o.mains_changed      = mains_ch;
    result_o.charger_changed    = chg_ch;

    if (!nxt.present)     result_o.battery_status = BatUnknown;
    else if (!nxt.mains)  result_o.battery_status = BatDischarging;
    else if (nxt.inhibit) result_o.battery_status = BatNotCharging;
    else if (full_cap)    result_o.battery_status = BatFull;
    else                  result_o.battery_status = BatCharging;

    if (!nxt.present) begin
      result_o.charge_band = LvlUnknown;
    end else if (on_batt_nz && nxt.voltage <= cfg_i.critical_uv) begin
      result_o.charge_band = LvlCritical;
    end else if (on_batt_nz && nxt.voltage <= cfg_i.low_uv) begin
      result_o.charge_band = LvlLow;
    end else if (nxt.mains && full_cap) begin
      result_o.charge_band = LvlFull;
    end else begin
      result_o.charge_band = LvlNormal;
    end

    if (!nxt.mains)       result_o.charger_status = ChgDischarging;
    else if (nxt.inhibit) result_o.charger_status = ChgNotCharging;
    else                  result_o.charger_status = ChgCharging;
  end

  assign state_o = nxt;

endmodule

>>> sv/battery_monitor_poll_classifier.sv
// top level of the battery monitor poll classifier: stream ports, config registers,
// input register, monitor state and result register; depends on bmpc_pkg and bmpc_update
`timescale 1ns / 1ps

// Battery monitor poll classifier. Each input word is one poll sample (voltage and
// state-of-charge reads with their success flags, mains pin and charge-inhibit pin);
// each produces exactly one result word with the stored voltage in microvolts,
// capacity percent, mains and inhibit levels, presence, change flags and the
// battery status, capacity level and charger status codes. Throughput is one word
// per clock while the output is not stalled: the sample sits in an input register,
// one short update stage (a 12 x 11 bit constant multiply plus compares, with the
// monitor state fed back in the same cycle) forms the result, and a result register
// drives the output, which m_axis_tvalid marks as valid. A stalled output holds the
// pipeline; s_axis_tready drops only when both registers are full and m_axis_tready
// is low. The user must write config registers (index 0 critical uV, 1 low uV,
// 2 full percent, 3 error limit) only while the block is idle; the block itself
// does not enforce this.
module battery_monitor_poll_classifier
  import bmpc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // config write port
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [UvW-1:0]      cfg_wdata_i,
  // sample stream
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // voltage_read_ok, voltage_raw[15:0], charge_read_ok, charge_raw[15:0],
  // mains_pin, mains_pin_ok, inhibit_pin, zero fill
  input  logic [InDataW-1:0]  s_axis_tdata,
  // result stream
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // battery_present, cell_microvolts[22:0], capacity_percent[6:0], mains_online,
  // charging_inhibited, battery_changed, mains_changed, charger_changed,
  // battery_status[2:0], charge_band[2:0], charger_status[1:0], zero fill
  output logic [OutDataW-1:0] m_axis_tdata
);

  localparam int unsigned ItemW = $bits(item_t);
  localparam int unsigned ResW  = $bits(result_t);

  // config registers
  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.critical_uv <= CriticalUvRst;
      cfg_q.low_uv      <= LowUvRst;
      cfg_q.full_pct    <= FullPctRst;
      cfg_q.err_limit   <= ErrLimitRst;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        RegCriticalUv: cfg_q.critical_uv <= cfg_wdata_i;
        RegLowUv:      cfg_q.low_uv      <= cfg_wdata_i;
        RegFullPct:    cfg_q.full_pct    <= cfg_wdata_i[PctW-1:0];
        RegErrLimit:   cfg_q.err_limit   <= cfg_wdata_i[ErrW-1:0];
        default: ;
      endcase
    end
  end

  // pipeline control
  logic    in_valid_q;
  item_t   in_item_q;
  logic    out_valid_q;
  result_t out_res_q;
  logic    advance;
  logic    s_acc;

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign s_acc         = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      in_item_q <= item_t'(s_axis_tdata[ItemW-1:0]);
    end
  end

  // monitor state and update stage
  state_t  state_q;
  state_t  state_d;
  result_t res_d;

  bmpc_update u_update (
    .cfg_i    (cfg_q),
    .state_i  (state_q),
    .item_i   (in_item_q),
    .state_o  (state_d),
    .result_o (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.voltage  <= '0;
      state_q.capacity <= '0;
      state_q.mains    <= 1'b0;
      state_q.inhibit  <= 1'b0;
      state_q.present  <= 1'b1;
      state_q.err_cnt  <= '0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {(OutDataW - ResW)'(0), out_res_q};

`ifndef SYNTH
  // an absent battery always reports unknown status and level
  a_absent_unknown: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_res_q.battery_present) |->
      (out_res_q.battery_status == BatUnknown && out_res_q.charge_band == LvlUnknown))
    else $error("absent battery without unknown codes");

  // off mains the charger must report discharging
  a_no_mains_dischg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_res_q.mains_online) |->
      (out_res_q.charger_status == ChgDischarging))
    else $error("charger status wrong off mains");

  // a mains change forces the battery change flag
  a_mains_forces_bat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_res_q.mains_changed) |-> out_res_q.battery_changed)
    else $error("mains change without battery change");

  // a held input word keeps its contents until it moves on
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !advance) |=> (in_valid_q && $stable(in_item_q)))
    else $error("input register lost a waiting word");

  // state only moves when a word passes to the result register
  a_state_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(state_q))
    else $error("state changed without an update");
`endif

endmodule
